// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the eikonal update block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- rtl/eik_pkg.sv -----
// Types and constants of the eikonal upwind cell update.
package eik_pkg;
   localparam int VALUE_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int VW = VALUE_BITS;
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NONE   = 2'd1;
   localparam logic [1:0] ST_NEGDSC = 2'd2;
   localparam logic       REG_SPACING = 1'b0;
   localparam logic       REG_DIMS    = 1'b1;
   // Dimensions value that brings in the z neighbours.
   localparam logic [1:0] DIMS_3D = 2'd3;
   // Spacing after reset: 1.0 in the value format.
   localparam logic [VW-1:0] SPACING_RESET = VW'(1) << FRAC_BITS;

   typedef struct packed {
      logic [VW-1:0] left_x_value;
      logic          left_x_done;
      logic [VW-1:0] right_x_value;
      logic          right_x_done;
      logic [VW-1:0] left_y_value;
      logic          left_y_done;
      logic [VW-1:0] right_y_value;
      logic          right_y_done;
      logic [VW-1:0] left_z_value;
      logic          left_z_done;
      logic [VW-1:0] right_z_value;
      logic          right_z_done;
   } req_type;

   typedef struct packed {
      logic [VW-1:0] new_distance;
      logic [1:0]    status;
   } rsp_type;
endpackage

// ----- rtl/eik_isqrt.sv -----
// Pipelined integer square root, rounded down, two result bits per stage.
module eik_isqrt #(
   parameter int IN_BITS = 68
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [IN_BITS-1:0]   radicand,
   output logic [IN_BITS/2-1:0] root
);
   localparam int RB = IN_BITS / 2;
   localparam int STAGES = (RB + 1) / 2;

   logic [IN_BITS-1:0] rem_ff [STAGES];
   logic [RB-1:0]      root_ff [STAGES];
   logic [IN_BITS-1:0] rem_in [STAGES];
   logic [RB-1:0]      root_in [STAGES];

   // Resolve two root bits per stage by restoring trial subtraction.
   for (genvar s = 0; s < STAGES; s++) begin : g_st
      logic [IN_BITS-1:0] rem_cur;
      logic [RB-1:0]      root_cur;
      if (s == 0) begin : g_head
         assign rem_cur = radicand;
         assign root_cur = '0;
      end else begin : g_tail
         assign rem_cur = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
      end
      always_comb begin
         logic [IN_BITS-1:0] r;
         logic [RB-1:0]      q;
         logic [IN_BITS+1:0] trial;
         r = rem_cur;
         q = root_cur;
         trial = '0;
         for (int b = 0; b < 2; b++) begin
            if ((2*s + b) < RB) begin
               trial = ({2'b0, q} << (RB - (2*s+b))) |
                       ({{(IN_BITS+1){1'b0}}, 1'b1} << (2*(RB - 1 - (2*s+b))));
               if ({2'b0, r} >= trial) begin
                  r = r - trial[IN_BITS-1:0];
                  q = q | (RB'(1) << (RB - 1 - (2*s+b)));
               end
            end
         end
         rem_in[s] = r;
         root_in[s] = q;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s] <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end
   assign root = root_ff[STAGES-1];
endmodule

// ----- rtl/eikonal_upwind_cell_update.sv -----
// Top level: fully pipelined upwind eikonal cell update.
//  channel | dir | handshake        | payload
//  req     | in  | req_valid/stall  | eik_pkg::req_type
//  rsp     | out | rsp_valid/stall  | eik_pkg::rsp_type
//  csr     | in  | csr_valid/ready  | csr_index, csr_data
// One item per cycle unless rsp stalls; 23 register stages: four in front (axis
// minimum, differences, squares, case select), 17 in the square root at two root bits
// each, and two behind (root add with reciprocal products, final select).
// Synchronous reset clears the valid bits and sets the configuration registers to their reset values.
// A stalled rsp item holds every stage; req_stall follows it in the same cycle.
`include "assert_macros.svh"
module eikonal_upwind_cell_update (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  eik_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output eik_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [31:0]      csr_data
);
   localparam int VW = eik_pkg::VW;
   localparam int SQW = 2*VW + 4;
   localparam int SQS = (SQW/2 + 1) / 2;
   localparam int LAT = 6 + SQS;
   localparam logic [VW-1:0] VMAX = '1;
   // Division by three through a reciprocal: QW-bit dividend, split in two halves.
   localparam int QW = VW + 2;
   localparam int QH = QW / 2;
   localparam int PW = QH + QW;
   localparam logic [63:0] RECIP3_W = ((64'd1 << (QW + 1)) + 64'd1) / 64'd3;
   localparam logic [QW-1:0] RECIP3 = RECIP3_W[QW-1:0];
   localparam logic [SQW/2+1:0] SAT3 = (SQW/2+2)'(3) << VW;

   logic [VW-1:0] spacing_ff;
   logic [1:0]    dims_ff;

   assign csr_ready = 1'b1;
   // Write configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= eik_pkg::SPACING_RESET;
         dims_ff <= eik_pkg::DIMS_3D;
      end else if (csr_valid) begin
         if (csr_index == eik_pkg::REG_SPACING) spacing_ff <= csr_data[VW-1:0];
         else dims_ff <= csr_data[1:0];
      end
   end

   logic advance;
   logic [LAT-1:0] vld_ff;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[LAT-1];

   // Advance valid bits with the data.
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[LAT-2:0], req_valid};
   end

   // Stage 1: per-axis minimum and compaction.
   logic [VW-1:0] p_ff [3];
   logic [1:0]    n_ff;
   logic [VW-1:0] dx1_ff;
   always_ff @(posedge clock) begin
      logic [VW-1:0] ax [3];
      logic          ad [3];
      logic [VW-1:0] pp [3];
      logic [1:0]    n;
      ax[0] = req_data.left_x_done && req_data.right_x_done ?
              (req_data.left_x_value < req_data.right_x_value ?
               req_data.left_x_value : req_data.right_x_value) :
              (req_data.left_x_done ? req_data.left_x_value : req_data.right_x_value);
      ad[0] = req_data.left_x_done || req_data.right_x_done;
      ax[1] = req_data.left_y_done && req_data.right_y_done ?
              (req_data.left_y_value < req_data.right_y_value ?
               req_data.left_y_value : req_data.right_y_value) :
              (req_data.left_y_done ? req_data.left_y_value : req_data.right_y_value);
      ad[1] = req_data.left_y_done || req_data.right_y_done;
      ax[2] = req_data.left_z_done && req_data.right_z_done ?
              (req_data.left_z_value < req_data.right_z_value ?
               req_data.left_z_value : req_data.right_z_value) :
              (req_data.left_z_done ? req_data.left_z_value : req_data.right_z_value);
      ad[2] = (req_data.left_z_done || req_data.right_z_done) &&
              dims_ff == eik_pkg::DIMS_3D;
      pp[0] = '0; pp[1] = '0; pp[2] = '0;
      n = 2'd0;
      for (int k = 0; k < 3; k++) begin
         if (ad[k]) begin
            pp[n] = ax[k];
            n = n + 2'd1;
         end
      end
      if (advance) begin
         p_ff <= pp;
         n_ff <= n;
         dx1_ff <= spacing_ff;
      end
   end

   function automatic logic [VW-1:0] d12_abs(input logic [VW-1:0] a, input logic [VW-1:0] b);
      d12_abs = a > b ? a - b : b - a;
   endfunction

   // Stage 2: differences and drop choice.
   logic [VW-1:0] d01_ff, d12_ff, d02_ff, dd_ff;
   logic [VW-1:0] a2_ff, b2_ff, c2_ff;
   logic [1:0]    n2_ff;
   logic [VW-1:0] dx2_ff;
   always_ff @(posedge clock) begin
      logic [1:0] m;
      m = 2'd0;
      if (p_ff[1] > p_ff[0]) m = 2'd1;
      if (p_ff[2] > p_ff[m]) m = 2'd2;
      // fewer than three axes: keep the first pair as it stands
      if (n_ff != 2'd3) m = 2'd2;
      if (advance) begin
         d01_ff <= p_ff[0] > p_ff[1] ? p_ff[0]-p_ff[1] : p_ff[1]-p_ff[0];
         d12_ff <= p_ff[1] > p_ff[2] ? p_ff[1]-p_ff[2] : p_ff[2]-p_ff[1];
         d02_ff <= p_ff[0] > p_ff[2] ? p_ff[0]-p_ff[2] : p_ff[2]-p_ff[0];
         // two-value pair after a possible drop (a2, b2), c2 the third value
         a2_ff <= (m == 2'd0) ? p_ff[1] : p_ff[0];
         b2_ff <= (m == 2'd2) ? p_ff[1] : p_ff[2];
         c2_ff <= p_ff[m];
         n2_ff <= n_ff;
         dx2_ff <= dx1_ff;
         dd_ff <= (m == 2'd0) ? d12_abs(p_ff[1], p_ff[2]) :
                  (m == 2'd1) ? d12_abs(p_ff[0], p_ff[2]) : d12_abs(p_ff[0], p_ff[1]);
      end
   end

   // Stage 3: squares.
   logic [2*VW-1:0] s01_ff, s12_ff, s02_ff, sdd_ff, sdx_ff;
   logic [VW-1:0]   a3_ff, b3_ff, c3_ff, dd3_ff, dx3_ff, d01_3_ff;
   logic [1:0]      n3_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         s01_ff <= d01_ff * d01_ff;
         s12_ff <= d12_ff * d12_ff;
         s02_ff <= d02_ff * d02_ff;
         sdd_ff <= dd_ff * dd_ff;
         sdx_ff <= dx2_ff * dx2_ff;
         a3_ff <= a2_ff; b3_ff <= b2_ff; c3_ff <= c2_ff;
         dd3_ff <= dd_ff; dx3_ff <= dx2_ff; d01_3_ff <= d01_ff;
         n3_ff <= n2_ff;
      end
   end

   // Stage 4: choose case, form radicand and linear sum.
   logic [SQW-1:0] rad_ff;
   logic [VW+1:0]  lin_ff;
   logic [VW:0]    direct_ff;
   logic           use_direct_ff, div3_ff;
   logic [1:0]     st_ff;
   always_ff @(posedge clock) begin
      logic [SQW-1:0] s3, d3, d2;
      logic [VW-1:0]  x, y, dif, dx;
      logic [2*VW-1:0] sq;
      logic           neg;
      s3 = SQW'(s01_ff) + SQW'(s12_ff) + SQW'(s02_ff);
      d3 = SQW'(sdx_ff) * SQW'(3);
      neg = (n3_ff == 2'd3) && (s3 > d3);
      dx = dx3_ff;
      if (n3_ff == 2'd3 && !neg) begin
         x = a3_ff; y = b3_ff; dif = '0; sq = '0;
      end else if (n3_ff == 2'd3) begin
         x = a3_ff; y = b3_ff; dif = dd3_ff; sq = sdd_ff;
      end else begin
         x = a3_ff; y = b3_ff;
         dif = d01_3_ff; sq = s01_ff;
      end
      d2 = (SQW'(sdx_ff) << 1) - SQW'(sq);
      if (advance) begin
         div3_ff <= (n3_ff == 2'd3) && !neg;
         st_ff <= (n3_ff == 2'd0) ? eik_pkg::ST_NONE :
                  (neg ? eik_pkg::ST_NEGDSC : eik_pkg::ST_OK);
         if (n3_ff == 2'd3 && !neg) begin
            rad_ff <= d3 - s3;
            lin_ff <= (VW+2)'(a3_ff) + (VW+2)'(b3_ff) + (VW+2)'(c3_ff);
            use_direct_ff <= 1'b0;
            direct_ff <= '0;
         end else if (n3_ff == 2'd1) begin
            rad_ff <= '0; lin_ff <= '0;
            use_direct_ff <= 1'b1;
            direct_ff <= (VW+1)'(a3_ff) + (VW+1)'(dx);
         end else if (n3_ff == 2'd0) begin
            rad_ff <= '0; lin_ff <= '0;
            use_direct_ff <= 1'b1;
            direct_ff <= {1'b1, VMAX};
         end else if (dif >= dx) begin
            rad_ff <= '0; lin_ff <= '0;
            use_direct_ff <= 1'b1;
            direct_ff <= (VW+1)'(x < y ? x : y) + (VW+1)'(dx);
         end else begin
            rad_ff <= d2;
            lin_ff <= (VW+2)'(x) + (VW+2)'(y);
            use_direct_ff <= 1'b0;
            direct_ff <= '0;
         end
      end
   end

   logic [SQW/2-1:0] root;
   eik_isqrt #(.IN_BITS(SQW)) u_sqrt (
      .clock(clock), .advance(advance),
      .radicand(rad_ff), .root(root)
   );

   // Delay side data alongside the root pipeline.
   logic [VW+1:0] lin_d_ff [SQS];
   logic [VW:0]   dir_d_ff [SQS];
   logic          ud_d_ff [SQS];
   logic          d3_d_ff [SQS];
   logic [1:0]    st_d_ff [SQS];
   always_ff @(posedge clock) begin
      if (advance) begin
         lin_d_ff[0] <= lin_ff; dir_d_ff[0] <= direct_ff;
         ud_d_ff[0] <= use_direct_ff; d3_d_ff[0] <= div3_ff; st_d_ff[0] <= st_ff;
         for (int i = 1; i < SQS; i++) begin
            lin_d_ff[i] <= lin_d_ff[i-1]; dir_d_ff[i] <= dir_d_ff[i-1];
            ud_d_ff[i] <= ud_d_ff[i-1]; d3_d_ff[i] <= d3_d_ff[i-1];
            st_d_ff[i] <= st_d_ff[i-1];
         end
      end
   end

   // Final stage one: add root, halve or saturate, form reciprocal products for a third.
   logic [SQW/2+1:0] tot, half;
   logic [VW-1:0]    fix_in, fix_ff;
   logic             use_fix_in, use_fix_ff;
   logic [PW-1:0]    ph_in, pl_in, ph_ff, pl_ff;
   logic [1:0]       stf_ff;
   always_comb begin
      tot = (SQW/2+2)'(root) + (SQW/2+2)'(lin_d_ff[SQS-1]);
      half = tot >> 1;
      ph_in = PW'(tot[QW-1:QH]) * PW'(RECIP3);
      pl_in = PW'(tot[QH-1:0]) * PW'(RECIP3);
      use_fix_in = 1'b1;
      if (ud_d_ff[SQS-1])
         fix_in = dir_d_ff[SQS-1][VW] ? VMAX : dir_d_ff[SQS-1][VW-1:0];
      else if (!d3_d_ff[SQS-1])
         fix_in = (half > (SQW/2+2)'(VMAX)) ? VMAX : half[VW-1:0];
      else if (tot >= SAT3)
         fix_in = VMAX;
      else begin
         fix_in = '0;
         use_fix_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         ph_ff <= ph_in; pl_ff <= pl_in;
         fix_ff <= fix_in; use_fix_ff <= use_fix_in;
         stf_ff <= st_d_ff[SQS-1];
      end
   end

   // Final stage two: finish the third and pick the result.
   logic [2*QW-1:0] prod;
   eik_pkg::rsp_type out_in, out_ff;
   always_comb begin
      prod = ((2*QW)'(ph_ff) << QH) + (2*QW)'(pl_ff);
      out_in.status = stf_ff;
      out_in.new_distance = use_fix_ff ? fix_ff : prod[QW+1 +: VW];
   end
   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end
   assign rsp_data = out_ff;

   logic rsp_none;
   assign rsp_none = rsp_valid && rsp_data.status == eik_pkg::ST_NONE;

   `ASSERT_CLK(a_stall_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   `ASSERT_CLK(a_req_stall, clock, reset, req_stall == (rsp_valid && rsp_stall))
   `ASSERT_CLK(a_none_max, clock, reset, rsp_none |-> rsp_data.new_distance == VMAX)
   `ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_valid)
endmodule
